/* src/rabe_pkg.sv */
// ----------------------------------------------------------------------------
// rabe_pkg: shared types and constants for the register ALU / branch unit
// Holds the opcode codes, the register file geometry and the status codes.
// ----------------------------------------------------------------------------
package rabe_pkg;
    localparam int NUM_REGS = 16;
    localparam int PC_INDEX = 15;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam logic [REG_AW-1:0] PC_SEL = REG_AW'(PC_INDEX % NUM_REGS);

    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_MUL = 4'd3;
    localparam logic [3:0] OP_DIV = 4'd4;
    localparam logic [3:0] OP_MOD = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_AND = 4'd7;
    localparam logic [3:0] OP_OR  = 4'd8;
    localparam logic [3:0] OP_CMP = 4'd9;
    localparam logic [3:0] OP_JZ  = 4'd10;
    localparam logic [3:0] OP_JNZ = 4'd11;
    localparam logic [3:0] OP_JMP = 4'd12;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_BADJMP = 2'd2;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_div_rsp;
endpackage

/* src/rabe_divider.sv */
// ----------------------------------------------------------------------------
// rabe_divider: iterative signed divide / remainder
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rabe_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rabe_pkg::t_div_req i_req,
    output rabe_pkg::t_div_rsp o_rsp
);
    import rabe_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_qneg, n_qneg;
    logic        r_rneg, n_rneg;
    logic        r_mod, n_mod;
    logic        r_done, n_done;
    logic [31:0] r_res, n_res;

    logic [32:0] w_trial;
    logic [31:0] w_shrem;
    logic [31:0] w_q, w_r;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_rem = r_rem; n_quo = r_quo;
        n_den = r_den; n_qneg = r_qneg; n_rneg = r_rneg; n_mod = r_mod;
        n_done = 1'b0; n_res = r_res;
        w_shrem = {r_rem[30:0], r_quo[31]};
        w_trial = {1'b0, w_shrem} - {1'b0, r_den};
        w_q = 32'd0; w_r = 32'd0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 32'd0;
            n_quo  = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            n_den  = i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            n_qneg = i_req.dividend[31] ^ i_req.divisor[31];
            n_rneg = i_req.dividend[31];
            n_mod  = i_req.is_mod;
        end else if (r_busy) begin
            // remainder and quotient shift together; quotient bits fill from the bottom
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_shrem;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                w_q = r_qneg ? (32'd0 - n_quo) : n_quo;
                w_r = r_rneg ? (32'd0 - n_rem) : n_rem;
                n_res = r_mod ? w_r : w_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_den <= n_den; r_qneg <= n_qneg;
        r_rneg <= n_rneg; r_mod <= n_mod; r_res <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;
endmodule

/* src/register_alu_branch_execute_top.sv */
// ----------------------------------------------------------------------------
// register_alu_branch_execute_top: execute unit of a 32-bit register machine
// Register file, compare flag, ALU, jump checks and a shared divider.
// ----------------------------------------------------------------------------
// ALU ops and jumps go from S_IDLE through S_EXEC to S_OUT; div and mod also wait in S_DIV
// for the bit-serial divider (divide by zero and 0x80000000 / -1 skip it)
// throughput: one instruction at a time; ready returns once the result is taken
// reset: registers and compare flag zero, program_length 65536
module register_alu_branch_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: action[3:0], use_register[4], dest_reg[8:5], src_reg[12:9], immediate[44:13]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], equal_flag[2], written_value[34:3], branch_taken[35]
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);
    import rabe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [31:0] r_regs [NUM_REGS];
    logic        r_flag;
    logic [16:0] r_plen;
    logic [3:0]  r_act;
    logic        r_use;
    logic [REG_AW-1:0] r_d, r_s;
    logic [31:0] r_imm;
    logic [1:0]  r_status;
    logic [31:0] r_wval;
    logic        r_taken;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [31:0] w_a, w_b, w_alu, w_off, w_tgt, w_pc;
    logic [31:0] w_prod;
    logic        w_go, w_ok;

    assign w_a  = r_regs[r_d];
    assign w_b  = r_use ? r_regs[r_s] : r_imm;
    assign w_pc = r_regs[PC_SEL];
    // low word only, wraps like the rest of the ALU
    assign w_prod = w_a * w_b;
    assign w_off = r_use ? w_a : {{24{r_imm[7]}}, r_imm[7:0]};
    assign w_tgt = w_pc + w_off;
    // signed target + 1 < length; any negative target passes
    assign w_ok = w_tgt[31] || ({1'b0, w_tgt} + 33'd1 < {16'd0, r_plen});
    assign w_go = (r_act == OP_JMP) || (r_act == OP_JZ && !r_flag)
               || (r_act == OP_JNZ && r_flag);

    always_comb begin
        unique case (r_act)
            OP_MOV:  w_alu = w_b;
            OP_ADD:  w_alu = w_a + w_b;
            OP_SUB:  w_alu = w_a - w_b;
            OP_MUL:  w_alu = w_prod;
            OP_XOR:  w_alu = w_a ^ w_b;
            OP_AND:  w_alu = w_a & w_b;
            OP_OR:   w_alu = w_a | w_b;
            default: w_alu = w_a;
        endcase
    end

    assign w_req.start    = (r_state == S_EXEC) && (r_act == OP_DIV || r_act == OP_MOD)
                            && (w_b != 32'd0)
                            && !(w_a == 32'h8000_0000 && w_b == 32'hFFFF_FFFF);
    assign w_req.is_mod   = (r_act == OP_MOD);
    assign w_req.dividend = w_a;
    assign w_req.divisor  = w_b;

    rabe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_taken, r_wval, r_flag, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flag  <= 1'b0;
            r_plen  <= 17'h10000;
            for (int k = 0; k < NUM_REGS; k++) r_regs[k] <= 32'd0;
        end else begin
            if (i_cfg_valid) r_plen <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act <= s_axis_tdata[3:0];
                        r_use <= s_axis_tdata[4];
                        r_d   <= s_axis_tdata[5 +: REG_AW];
                        r_s   <= s_axis_tdata[9 +: REG_AW];
                        r_imm <= s_axis_tdata[44:13];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_taken  <= 1'b0;
                    r_wval   <= w_a;
                    r_state  <= S_OUT;
                    if (r_act <= OP_OR && r_act != OP_DIV && r_act != OP_MOD) begin
                        r_regs[r_d] <= w_alu;
                        r_wval      <= w_alu;
                    end else if (r_act == OP_DIV || r_act == OP_MOD) begin
                        if (w_b == 32'd0) begin
                            r_status <= ST_DIV0;
                        end else if (w_a == 32'h8000_0000 && w_b == 32'hFFFF_FFFF) begin
                            r_regs[r_d] <= (r_act == OP_DIV) ? w_a : 32'd0;
                            r_wval      <= (r_act == OP_DIV) ? w_a : 32'd0;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else if (r_act == OP_CMP) begin
                        r_flag <= (w_a == w_b);
                    end else if (r_act >= OP_JZ && r_act <= OP_JMP) begin
                        r_wval <= w_pc;
                        if (w_go) begin
                            if (w_ok) begin
                                r_regs[PC_SEL] <= w_tgt;
                                r_wval  <= w_tgt;
                                r_taken <= 1'b1;
                            end else begin
                                r_status <= ST_BADJMP;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_regs[r_d] <= w_rsp.result;
                        r_wval      <= w_rsp.result;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* bench/register_alu_branch_execute_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_alu_branch_execute_top_tb: self-checking bench for the execute unit
// Drives decoded instructions over the input stream, predicts each result with
// a local copy of the register file, compare flag and program length, and
// checks every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module register_alu_branch_execute_top_tb;
    import rabe_pkg::*;

    typedef struct packed {
        logic        taken;
        logic [31:0] value;
        logic        eq;
        logic [1:0]  status;
    } t_outcome;

    class exec_scoreboard;
        logic [31:0] regs[NUM_REGS];
        logic        flag;
        logic [16:0] prog_len;
        t_outcome    pending[$];
        int          errors;

        function void clear();
            foreach (regs[k]) regs[k] = '0;
            flag = 1'b0;
            prog_len = 17'd65536;
            errors = 0;
        endfunction

        // apply one instruction to the shadow state and queue its outcome
        function void note_instr(logic [3:0] op, logic use_r, logic [3:0] d,
                                 logic [3:0] s, logic [31:0] imm);
            logic [31:0] a, b, r, off, tgt;
            logic signed [31:0] sa, sb;
            t_outcome o;
            logic go;
            a = regs[d];
            b = use_r ? regs[s] : imm;
            sa = a;
            sb = b;
            o = '0;
            o.status = ST_OK;
            case (op)
                OP_MOV: r = b;
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                OP_XOR: r = a ^ b;
                OP_AND: r = a & b;
                default: r = a | b;
            endcase
            if (op <= OP_OR && op != OP_DIV && op != OP_MOD) begin
                regs[d] = r;
                o.value = r;
            end else if (op == OP_DIV || op == OP_MOD) begin
                if (b == 0) begin
                    o.status = ST_DIV0;
                    o.value = a;
                end else begin
                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                        r = (op == OP_DIV) ? a : 32'd0;
                    else if (op == OP_DIV)
                        r = sa / sb;
                    else
                        r = sa % sb;
                    regs[d] = r;
                    o.value = r;
                end
            end else if (op == OP_CMP) begin
                flag = (a == b);
                o.value = a;
            end else if (op == OP_JZ || op == OP_JNZ || op == OP_JMP) begin
                go = (op == OP_JMP) || (op == OP_JZ && !flag) || (op == OP_JNZ && flag);
                if (go) begin
                    off = use_r ? regs[d] : {{24{imm[7]}}, imm[7:0]};
                    tgt = regs[PC_SEL] + off;
                    if ($signed({{32{tgt[31]}}, tgt}) + 64'sd1 < $signed({47'd0, prog_len})) begin
                        regs[PC_SEL] = tgt;
                        o.taken = 1'b1;
                    end else begin
                        o.status = ST_BADJMP;
                    end
                end
                o.value = regs[PC_SEL];
            end else begin
                o.value = a;
            end
            o.eq = flag;
            pending.push_back(o);
        endfunction

        function void check_result(logic [39:0] data);
            t_outcome got, exp;
            got = data[35:0];
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp = pending.pop_front();
                if (got.status !== exp.status)
                    $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
                if (got.eq !== exp.eq)
                    $display("%0t equal_flag exp %0d got %0d", $time, exp.eq, got.eq);
                if (got.value !== exp.value)
                    $display("%0t written_value exp %h got %h", $time, exp.value, got.value);
                if (got.taken !== exp.taken)
                    $display("%0t branch_taken exp %0d got %0d", $time, exp.taken, got.taken);
                if (got !== exp || data[39:36] !== 4'd0) errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;

    exec_scoreboard exec_sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    register_alu_branch_execute_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            exec_sb.check_result(m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high after a transaction so back-to-back sends need no gap
    task automatic send_instr(logic [3:0] op, logic use_r, logic [3:0] d,
                              logic [3:0] s, logic [31:0] imm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'd0, imm, s, d, use_r, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exec_sb.note_instr(op, use_r, d, s, imm);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (exec_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_length(logic [16:0] len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        exec_sb.prog_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(3);
            4: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_instr();
        logic [3:0] op;
        if ($urandom_range(19) == 0) op = 4'($urandom_range(15, 13));
        else op = 4'($urandom_range(12));
        send_instr(op, 1'($urandom_range(1)), 4'($urandom_range(15)),
                   4'($urandom_range(15)), rand_word());
    endtask

    initial begin
        exec_sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation, special cases
        send_instr(OP_MOV, 0, 4'd1, 4'd0, 32'h8000_0000);
        send_instr(OP_MOV, 0, 4'd2, 4'd0, 32'hFFFF_FFFF);
        send_instr(OP_DIV, 1, 4'd1, 4'd2, 32'd0);
        send_instr(OP_MOV, 0, 4'd1, 4'd0, 32'h8000_0000);
        send_instr(OP_MOD, 1, 4'd1, 4'd2, 32'd0);
        send_instr(OP_DIV, 0, 4'd2, 4'd0, 32'd0);
        send_instr(OP_MOD, 1, 4'd2, 4'd3, 32'd0);
        send_instr(OP_MOV, 0, 4'd3, 4'd0, 32'h7FFF_FFFF);
        send_instr(OP_ADD, 0, 4'd3, 4'd0, 32'd1);
        send_instr(OP_SUB, 1, 4'd3, 4'd2, 32'd0);
        send_instr(OP_MUL, 0, 4'd3, 4'd0, 32'hFFFF_FFFF);
        send_instr(OP_XOR, 0, 4'd4, 4'd0, 32'h5555_AAAA);
        send_instr(OP_AND, 0, 4'd4, 4'd0, 32'hF0F0_F0F0);
        send_instr(OP_OR,  1, 4'd4, 4'd3, 32'd0);
        send_instr(OP_CMP, 1, 4'd5, 4'd6, 32'd0);
        send_instr(OP_JNZ, 0, 4'd0, 4'd0, 32'h0000_007F);
        send_instr(OP_JZ,  0, 4'd0, 4'd0, 32'h0000_0005);
        send_instr(OP_CMP, 0, 4'd5, 4'd0, 32'd7);
        send_instr(OP_JZ,  0, 4'd0, 4'd0, 32'd3);
        send_instr(OP_JMP, 0, 4'd0, 4'd0, 32'hFFFF_FF80);
        send_instr(OP_JMP, 1, 4'd1, 4'd0, 32'd0);
        send_instr(4'd13, 1, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_instr(4'd15, 0, 4'd3, 4'd0, 32'd0);
        write_length(17'd0);
        send_instr(OP_JMP, 0, 4'd0, 4'd0, 32'd1);
        send_instr(OP_MOV, 0, 4'd15, 4'd0, 32'hFFFF_FFFE);

        // random phases with varying length settings and idle rates
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            case (ph)
                0: write_length(17'd65536);
                1: write_length(17'd1);
                2: write_length(17'd300);
                3: write_length(17'd131071);
                default: write_length(17'($urandom_range(131071)));
            endcase
            if (ph == 2) hold_off = 200;
            // small program counter keeps jump checks near the limit
            if ($urandom_range(1)) send_instr(OP_MOV, 0, 4'd15, 4'd0, $urandom_range(400));
            for (int n = 0; n < 66; n++) rand_instr();
            if (ph == 5) drain();
        end

        drain();
        if (exec_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
src/rabe_pkg.sv
src/rabe_divider.sv
src/register_alu_branch_execute_top.sv
bench/register_alu_branch_execute_top_tb.sv
